FILE: hdl/dvd_pkg.sv
// Package for the double-ended queue: sizes, codes, types and the ring slot helper.
`timescale 1ns / 1ps

package dvd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CNT_W:0]        t_offset;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_DELETE     = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    // Ring position of an offset from the head. One conditional subtract wraps the
    // sum while it is below twice the depth; larger sums only address unused reads.
    function automatic t_addr slot(t_addr head, t_offset offset);
        logic [CNT_W+1:0] sum;
        sum = (CNT_W + 2)'(head) + (CNT_W + 2)'(offset);
        if (sum >= (CNT_W + 2)'(DEPTH)) begin
            sum = sum - (CNT_W + 2)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: hdl/dvd_if.sv
// Request and response channel interfaces of the double-ended queue.
`timescale 1ns / 1ps

interface dvd_req_if
    import dvd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [31:0]          data_value;

    modport source (output valid, output req_type, output data_value, input ready);
    modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface dvd_rsp_if
    import dvd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [31:0]          read_data;
    logic [STAT_W-1:0]    status;
    logic [CNT_W-1:0]     entry_count;

    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

FILE: hdl/dvd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module dvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/deque_with_value_delete.sv
// Bounded double-ended queue with delete-by-value, held in a ring RAM.
// Each request yields one response carrying the popped word (zero unless a pop
// succeeded), a status (ok, empty, full, not found) and the entry count after
// the request. For pushes, pops and unused codes, the accept cycle starts the
// RAM read and the execute state commits once the output register is free.
// A delete walks the entries from the front through the registered RAM read
// port, one entry per cycle, then moves each later entry down one place, one
// per cycle. A new request is taken whenever the block is idle, even while the
// previous response still waits in the output register; a finished request
// waits only if that register is full.
`timescale 1ns / 1ps

module deque_with_value_delete
    import dvd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dvd_req_if.sink     i_req,
    dvd_rsp_if.source   o_rsp
);

    t_state           r_state, n_state;
    t_addr            r_head, n_head;
    t_cnt             r_count, n_count;
    t_cnt             r_idx, n_idx;
    logic [REQ_W-1:0] r_req;
    t_word            r_word;

    logic             r_out_valid, n_out_valid;
    t_word            r_out_data, n_out_data;
    t_status          r_out_status, n_out_status;
    t_cnt             r_out_count, n_out_count;

    logic             w_ram_we, w_ram_re;
    t_addr            w_ram_waddr, w_ram_raddr;
    t_word            w_ram_wdata, w_ram_rdata;

    logic             w_accept, w_free, w_load;
    logic             w_full, w_empty, w_match;
    logic             w_scan_fin, w_shift_fin;
    t_addr            w_head_inc, w_head_dec;
    t_offset          w_idx_p1, w_idx_p2;

    dvd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_free      = !r_out_valid || o_rsp.ready;

    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_match     = (w_ram_rdata == r_word);
    assign w_idx_p1    = t_offset'(r_idx) + t_offset'(1);
    assign w_idx_p2    = t_offset'(r_idx) + t_offset'(2);
    assign w_head_inc  = (r_head == t_addr'(DEPTH - 1)) ? '0 : r_head + t_addr'(1);
    assign w_head_dec  = (r_head == '0) ? t_addr'(DEPTH - 1) : r_head - t_addr'(1);

    // In the scan the read data belongs to offset r_idx; the walk ends when it
    // runs past the held entries or when the match is the last entry.
    assign w_scan_fin  = (t_offset'(r_idx) >= t_offset'(r_count)) ||
                         (w_match && (w_idx_p1 >= t_offset'(r_count)));
    // In the shift the read data belongs to offset r_idx + 1 and is written to r_idx.
    assign w_shift_fin = (w_idx_p2 >= t_offset'(r_count));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.req_type == REQ_DELETE) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (w_scan_fin) begin
                    if (w_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (w_match) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (w_shift_fin && w_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        w_ram_we     = 1'b0;
        w_ram_waddr  = slot(r_head, t_offset'(r_count));
        w_ram_wdata  = r_word;
        w_ram_re     = 1'b0;
        w_ram_raddr  = slot(r_head, '0);
        w_load       = 1'b0;
        n_out_data   = '0;
        n_out_status = STAT_OK;

        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    w_ram_re = 1'b1;
                    if (i_req.req_type == REQ_POP_BACK) begin
                        w_ram_raddr = slot(r_head, t_offset'(r_count) - t_offset'(1));
                    end
                end
            end
            ST_EXEC: begin
                if (w_free) begin
                    w_load = 1'b1;
                    case (r_req)
                        REQ_PUSH_BACK: begin
                            if (w_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                w_ram_we = 1'b1;
                                n_count  = r_count + t_cnt'(1);
                            end
                        end
                        REQ_POP_BACK: begin
                            if (w_empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_out_data = w_ram_rdata;
                                n_count    = r_count - t_cnt'(1);
                            end
                        end
                        REQ_PUSH_FRONT: begin
                            if (w_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                w_ram_we    = 1'b1;
                                w_ram_waddr = w_head_dec;
                                n_head      = w_head_dec;
                                n_count     = r_count + t_cnt'(1);
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (w_empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_out_data = w_ram_rdata;
                                n_head     = w_head_inc;
                                n_count    = r_count - t_cnt'(1);
                            end
                        end
                        default: n_out_status = STAT_OK;
                    endcase
                end
            end
            ST_SCAN: begin
                w_ram_raddr = slot(r_head, w_idx_p1);
                if (w_scan_fin) begin
                    if (w_free) begin
                        w_load = 1'b1;
                        if (t_offset'(r_idx) >= t_offset'(r_count)) begin
                            n_out_status = STAT_NOT_FOUND;
                        end else begin
                            n_count = r_count - t_cnt'(1);
                        end
                    end
                end else begin
                    w_ram_re = 1'b1;
                    if (!w_match) begin
                        n_idx = w_idx_p1[CNT_W-1:0];
                    end
                end
            end
            ST_SHIFT: begin
                w_ram_waddr = slot(r_head, t_offset'(r_idx));
                w_ram_wdata = w_ram_rdata;
                w_ram_raddr = slot(r_head, w_idx_p2);
                if (!w_shift_fin) begin
                    w_ram_we = 1'b1;
                    w_ram_re = 1'b1;
                    n_idx    = w_idx_p1[CNT_W-1:0];
                end else if (w_free) begin
                    w_ram_we = 1'b1;
                    w_load   = 1'b1;
                    n_count  = r_count - t_cnt'(1);
                end
            end
            default: n_idx = '0;
        endcase

        n_out_count = n_count;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req.req_type;
            r_word <= i_req.data_value[DATA_WIDTH-1:0];
        end
        if (w_load) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out_data;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds the depth");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("request transfer did not start any work");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state != ST_IDLE))
        else $error("RAM written while idle");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && w_free && !w_full &&
         (r_req == REQ_PUSH_BACK || r_req == REQ_PUSH_FRONT))
        |=> (r_count == $past(r_count) + t_cnt'(1)))
        else $error("successful push did not add one entry");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (w_idx_p1 < t_offset'(r_count)))
        else $error("compaction moved past the held entries");

endmodule

FILE: bench/deque_with_value_delete_test.sv
// Self-checking testbench for the double-ended queue with delete-by-value.
`timescale 1ns / 1ps

module deque_with_value_delete_test
    import dvd_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 4 * DEPTH;
    localparam int unsigned LONG_HOLD = 300;

    // Request codes with no operation behind them; the block answers them without a change.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [31:0]      read_data;
        t_status          status;
        logic [CNT_W-1:0] entry_count;
    } t_deque_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dvd_req_if req_ch ();
    dvd_rsp_if rsp_ch ();

    deque_with_value_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the queue contents, updated at each accepted request.
    t_word       shadow_ring [DEPTH];
    int unsigned shadow_head;
    int unsigned shadow_count;

    t_deque_result pending_results [$];
    int unsigned   mismatch_count = 0;
    int unsigned   burst_left = 0;
    int unsigned   cycle_count = 0;
    int unsigned   hold_cycles_left = 0;
    logic [15:0]   ready_pattern = '1;
    int unsigned   pattern_step = 0;

    function automatic int unsigned ring_pos(int unsigned offset);
        return (shadow_head + offset) % DEPTH;
    endfunction

    function automatic t_deque_result apply_request(logic [REQ_W-1:0] code, logic [31:0] value);
        t_deque_result r;
        t_word         word;
        int unsigned   i;
        int unsigned   j;
        bit            hit;
        word = t_word'(value);
        r.read_data = '0;
        r.status = STAT_OK;
        case (code)
            REQ_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_ring[ring_pos(shadow_count)] = word;
                    shadow_count++;
                end
            end
            REQ_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    shadow_count--;
                    r.read_data = 32'(shadow_ring[ring_pos(shadow_count)]);
                end
            end
            REQ_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = word;
                    shadow_count++;
                end
            end
            REQ_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.read_data = 32'(shadow_ring[shadow_head]);
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            REQ_DELETE: begin
                // The first match from the front goes; later entries move down one place.
                r.status = STAT_NOT_FOUND;
                hit = 1'b0;
                for (i = 0; i < shadow_count && !hit; i++) begin
                    if (shadow_ring[ring_pos(i)] == word) begin
                        for (j = i; j + 1 < shadow_count; j++) begin
                            shadow_ring[ring_pos(j)] = shadow_ring[ring_pos(j + 1)];
                        end
                        shadow_count--;
                        r.status = STAT_OK;
                        hit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            4, 5: return 32'h5A00_0000 | $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // Picks a value that is held most of the time, so that deletes usually find a match.
    function automatic logic [31:0] pick_delete_word();
        if (shadow_count != 0 && $urandom_range(0, 3) != 0) begin
            return 32'(shadow_ring[ring_pos($urandom_range(0, shadow_count - 1))]);
        end
        return pick_word();
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] code, input logic [31:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= code;
        req_ch.data_value <= value;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_results.push_back(apply_request(code, value));
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Sends n counted requests; unused codes are mixed in but not counted.
    task automatic send_mixed(int unsigned n, int unsigned push_pct, int unsigned del_pct);
        int unsigned sent;
        int unsigned roll;
        sent = 0;
        while (sent < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_item(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), $urandom);
            end else begin
                if (roll < 3 + del_pct) begin
                    send_item(REQ_DELETE, pick_delete_word());
                end else if (roll < 3 + del_pct + push_pct) begin
                    send_item($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_word());
                end else begin
                    send_item($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
                end
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        logic [31:0] fill_words [16];
        int          i;
        fill_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                       32'hDEAD_BEEF, 32'h1234_5678, 32'hDEAD_BEEF, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0F0F_0F0F,
                       32'hF0F0_F0F0, 32'h0000_8000, 32'h0001_0000, 32'hCAFE_0001};
        // Pops and a delete on an empty queue, then the unused codes.
        send_item(REQ_POP_BACK, 32'h0000_0000);
        send_item(REQ_POP_FRONT, 32'hFFFF_FFFF);
        send_item(REQ_DELETE, 32'h0000_0000);
        send_item(REQ_UNUSED_LO, 32'hFFFF_FFFF);
        send_item(REQ_UNUSED_LO + 1'b1, 32'h0000_0000);
        send_item(REQ_UNUSED_HI, 32'hA5A5_A5A5);
        for (i = 0; i < 16; i++) begin
            send_item(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, fill_words[i]);
        end
        send_item(REQ_PUSH_BACK, 32'h1111_1111);
        send_item(REQ_PUSH_FRONT, 32'h2222_2222);
        send_item(REQ_DELETE, 32'h3333_3333);
        send_item(REQ_DELETE, 32'hDEAD_BEEF);
        send_item(REQ_DELETE, 32'hCAFE_0001);
        send_item(REQ_POP_FRONT, 32'h0000_0000);
        send_item(REQ_POP_BACK, 32'h0000_0000);
        wait_all_results();
    endtask

    task automatic test_random_mix();
        int phase;
        for (phase = 0; phase < 11; phase++) begin
            case (phase % 3)
                0: send_mixed(50, 70, 10);
                1: send_mixed(50, 20, 15);
                default: send_mixed(50, 42, 16);
            endcase
            if (phase % 4 == 3) begin
                wait_all_results();
            end
        end
        wait_all_results();
    endtask

    // The receiver holds off while requests keep coming, so the block fills and stalls.
    task automatic test_back_pressure();
        hold_cycles_left <= LONG_HOLD;
        send_mixed(60, 80, 5);
        wait_all_results();
    endtask

    // Full queues with many duplicates keep the delete scan and compaction busy.
    task automatic test_delete_scan();
        repeat (6) begin
            while (shadow_count < DEPTH) begin
                send_item($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                          32'h5A00_0000 | $urandom_range(0, 5));
            end
            repeat (14) begin
                send_item(REQ_DELETE, ($urandom_range(0, 3) == 0)
                          ? 32'h5A00_0000 | $urandom_range(0, 7) : pick_delete_word());
            end
        end
        wait_all_results();
    endtask

    always @(posedge i_clk) begin : response_checker
        t_deque_result want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected response: data=%h status=%0d count=%0d",
                             rsp_ch.read_data, rsp_ch.status, rsp_ch.entry_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.read_data !== want.read_data || rsp_ch.status !== want.status ||
                    rsp_ch.entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"mismatch: expected data=%h status=%0d count=%0d, ",
                                  "got data=%h status=%0d count=%0d"},
                                 want.read_data, want.status, want.entry_count,
                                 rsp_ch.read_data, rsp_ch.status, rsp_ch.entry_count);
                    end
                end
            end
        end
        pattern_step <= pattern_step + 1;
        if (pattern_step % 64 == 63) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= '1;
                1: ready_pattern <= 16'($urandom);
                default: ready_pattern <= 16'($urandom | $urandom);
            endcase
        end
        if (hold_cycles_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles_left <= hold_cycles_left - 1;
        end else begin
            rsp_ch.ready <= ready_pattern[pattern_step % 16];
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** deque_with_value_delete: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PUSH_BACK;
        req_ch.data_value = '0;
        rsp_ch.ready = 1'b0;
        shadow_head = 0;
        shadow_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix();
        test_back_pressure();
        test_delete_scan();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** deque_with_value_delete: PASSED **");
        end else begin
            $display("** deque_with_value_delete: FAILED **");
        end
        $finish;
    end

endmodule
